// ===== sv/sbqeq_pkg.sv =====
package sbqeq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 26;
  localparam int ACC_BITS       = 64;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int TAPS           = 5;
  localparam int NUM_CHANNELS   = 2;
  localparam int CH_W           = 1;
  localparam int FUNC_BITS      = 2;
  localparam int CIDX_BITS      = 5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [ACC_BITS-1:0]           acc_t;

  localparam coef_t   COEF_ONE   = coef_t'(1) << COEF_FRAC_BITS;
  localparam acc_t    ROUND_HALF = acc_t'(1) << (COEF_FRAC_BITS - 1);
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_PROC     = 2'd0,
    FUNC_COEF_WR  = 2'd1,
    FUNC_HIST_CLR = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    TAP_B0 = 3'd0,
    TAP_B1 = 3'd1,
    TAP_B2 = 3'd2,
    TAP_A1 = 3'd3,
    TAP_A2 = 3'd4
  } tap_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP,
    S_WAIT,
    S_DONE,
    S_FIN,
    S_PUB
  } state_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    sample_t              left_in;
    sample_t              right_in;
    logic [CIDX_BITS-1:0] coef_index;
    coef_t                coef_value;
  } req_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } rsp_t;

  typedef struct packed {
    sample_t h1;
    sample_t h2;
  } hist_t;

  typedef struct packed {
    logic capture;
    logic coef_wr;
    logic hist_clr;
    logic load_x;
    logic hist_rd;
    logic tap_vld;
    tap_t tap;
    logic sec_done;
    logic fin;
    logic publish;
  } cmd_t;

endpackage

// ===== sv/sbqeq_dp.sv =====
module sbqeq_dp import sbqeq_pkg::*; #(
  parameter int NUM_SECTIONS = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  cmd_t                 cmd,
  input  logic [((NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1)-1:0] sec,
  input  logic [CH_W-1:0]      ch,
  output rsp_t                 rsp
);

  localparam int NUM_COEFS  = NUM_SECTIONS * TAPS;
  localparam int CA_W       = $clog2(NUM_COEFS);
  localparam int HIST_DEPTH = NUM_CHANNELS * (NUM_SECTIONS + 1);
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int RSH_BITS   = ACC_BITS - COEF_FRAC_BITS;

  coef_t                 coef_mem [NUM_COEFS];
  logic [NUM_COEFS-1:0]  coef_vld;
  logic [CA_W-1:0]       coef_ra;
  logic [CA_W-1:0]       coef_wa;
  logic                  coef_we;
  coef_t                 coef_rd;
  logic                  coef_rd_vld;
  coef_t                 coef_eff;

  hist_t                 hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld;
  logic [HA_W-1:0]       hist_base;
  logic [HA_W-1:0]       hist_ra0;
  logic [HA_W-1:0]       hist_ra1;
  logic [HA_W-1:0]       hist_wa;
  logic                  hist_we;
  hist_t                 hist_wd;
  hist_t                 rd0;
  hist_t                 rd1;
  logic                  rd0_vld;
  logic                  rd1_vld;
  hist_t                 xh;
  hist_t                 yh;

  sample_t               samp [NUM_CHANNELS];
  sample_t               x_cur;
  sample_t               res [NUM_CHANNELS];

  logic                  tap_vld_q;
  tap_t                  tap_q;
  sample_t               op;
  prod_t                 prod_d;
  prod_t                 prod_q;
  logic                  prod_vld;
  logic                  prod_neg;
  logic                  prod_first;
  acc_t                  pext;
  acc_t                  acc;

  acc_t                  rnd;
  logic [RSH_BITS-1:0]   rsh;
  logic [RSH_BITS-SAMPLE_BITS:0] rsh_hi;
  sample_t               y;

  // coefficient store
  assign coef_ra = CA_W'(sec) * CA_W'(TAPS) + CA_W'(cmd.tap);
  assign coef_wa = CA_W'(req.coef_index);
  assign coef_we = cmd.coef_wr && (32'(req.coef_index) < 32'(NUM_COEFS));

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= req.coef_value;
    end
    if (cmd.tap_vld) begin
      coef_rd     <= coef_mem[coef_ra];
      coef_rd_vld <= coef_vld[coef_ra];
      tap_q       <= cmd.tap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (coef_we) begin
      coef_vld[coef_wa] <= 1'b1;
    end
  end

  assign coef_eff = coef_rd_vld ? coef_rd : ((tap_q == TAP_B0) ? COEF_ONE : '0);

  // filter history
  assign hist_base = HA_W'(ch) * HA_W'(NUM_SECTIONS + 1);
  assign hist_ra0  = hist_base + HA_W'(sec);
  assign hist_ra1  = hist_ra0 + HA_W'(1);
  assign hist_wa   = cmd.sec_done ? hist_ra0 : hist_base + HA_W'(NUM_SECTIONS);
  assign hist_we   = cmd.sec_done || cmd.fin;
  assign hist_wd.h1 = x_cur;
  assign hist_wd.h2 = cmd.sec_done ? xh.h1 : yh.h1;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (cmd.hist_rd) begin
      rd0     <= hist_mem[hist_ra0];
      rd1     <= hist_mem[hist_ra1];
      rd0_vld <= hist_vld[hist_ra0];
      rd1_vld <= hist_vld[hist_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
    end else if (cmd.hist_clr) begin
      hist_vld <= '0;
    end else if (hist_we) begin
      hist_vld[hist_wa] <= 1'b1;
    end
  end

  assign xh = rd0_vld ? rd0 : '0;
  assign yh = rd1_vld ? rd1 : '0;

  // samples and section input
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp[0] <= req.left_in;
      samp[1] <= req.right_in;
    end
    if (cmd.load_x) begin
      x_cur <= samp[ch];
    end else if (cmd.sec_done) begin
      x_cur <= y;
    end
    if (cmd.fin) begin
      res[ch] <= x_cur;
    end
    if (cmd.publish) begin
      rsp.left_out  <= res[0];
      rsp.right_out <= res[1];
    end
  end

  // shared multiplier
  always_comb begin
    case (tap_q)
      TAP_B0:  op = x_cur;
      TAP_B1:  op = xh.h1;
      TAP_B2:  op = xh.h2;
      TAP_A1:  op = yh.h1;
      TAP_A2:  op = yh.h2;
      default: op = '0;
    endcase
  end

  assign prod_d = coef_eff * op;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_vld_q <= 1'b0;
      prod_vld  <= 1'b0;
    end else begin
      tap_vld_q <= cmd.tap_vld;
      prod_vld  <= tap_vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (tap_vld_q) begin
      prod_q     <= prod_d;
      prod_neg   <= (tap_q == TAP_A1) || (tap_q == TAP_A2);
      prod_first <= (tap_q == TAP_B0);
    end
  end

  // accumulate
  assign pext = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      acc <= (prod_first ? '0 : acc) + (prod_neg ? -pext : pext);
    end
  end

  // round half up, saturate
  assign rnd    = acc + ROUND_HALF;
  assign rsh    = rnd[ACC_BITS-1:COEF_FRAC_BITS];
  assign rsh_hi = rsh[RSH_BITS-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&rsh_hi) || !(|rsh_hi)) begin
      y = rsh[SAMPLE_BITS-1:0];
    end else if (rsh[RSH_BITS-1]) begin
      y = SAMPLE_MIN;
    end else begin
      y = SAMPLE_MAX;
    end
  end

endmodule

// ===== sv/sbqeq_ctrl.sv =====
module sbqeq_ctrl import sbqeq_pkg::*; #(
  parameter int NUM_SECTIONS = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [FUNC_BITS-1:0] func,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cmd_t                 cmd,
  output logic [((NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1)-1:0] sec,
  output logic [CH_W-1:0]      ch
);

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

  state_t           state;
  state_t           state_next;
  logic [SEC_W-1:0] sec_next;
  logic [CH_W-1:0]  ch_next;
  tap_t             tap;
  tap_t             tap_next;
  logic             wcnt;
  logic             wcnt_next;
  logic             rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sec       <= '0;
      ch        <= '0;
      tap       <= TAP_B0;
      wcnt      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sec       <= sec_next;
      ch        <= ch_next;
      tap       <= tap_next;
      wcnt      <= wcnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    sec_next   = sec;
    ch_next    = ch;
    tap_next   = tap;
    wcnt_next  = wcnt;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.tap    = tap;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (func_t'(func))
            FUNC_PROC: begin
              cmd.capture = 1'b1;
              sec_next    = '0;
              ch_next     = '0;
              tap_next    = TAP_B0;
              state_next  = S_TAP;
            end
            FUNC_COEF_WR:  cmd.coef_wr  = 1'b1;
            FUNC_HIST_CLR: cmd.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_TAP: begin
        cmd.tap_vld = 1'b1;
        cmd.hist_rd = (tap == TAP_B0);
        cmd.load_x  = (tap == TAP_B0) && (sec == '0);
        if (tap == TAP_A2) begin
          wcnt_next  = 1'b0;
          state_next = S_WAIT;
        end else begin
          tap_next = tap_t'(tap + 3'd1);
        end
      end
      S_WAIT: begin
        if (wcnt) begin
          state_next = S_DONE;
        end else begin
          wcnt_next = 1'b1;
        end
      end
      S_DONE: begin
        cmd.sec_done = 1'b1;
        tap_next     = TAP_B0;
        if (sec == SEC_W'(NUM_SECTIONS - 1)) begin
          state_next = S_FIN;
        end else begin
          sec_next   = sec + SEC_W'(1);
          state_next = S_TAP;
        end
      end
      S_FIN: begin
        cmd.fin  = 1'b1;
        sec_next = '0;
        tap_next = TAP_B0;
        if (ch == CH_W'(NUM_CHANNELS - 1)) begin
          state_next = S_PUB;
        end else begin
          ch_next    = ch + CH_W'(1);
          state_next = S_TAP;
        end
      end
      S_PUB: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    rsp_valid_next = cmd.publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid);
  end

endmodule

// ===== sv/stereo_biquad_cascade_eq.sv =====
// Stereo five-section biquad equalizer, direct form I, shared coefficients.
// Request channel (req_valid/req_ready/req): func selects processing of a
// sample pair, a coefficient write (coef_index, coef_value) or a history
// clear. Only a processed pair gives a response on rsp_valid/rsp_ready.
// Coefficient writes, history clears and unknown codes are handled in idle
// and the block is ready again in the next cycle.
// A sample pair runs through both channels one after the other on a single
// multiplier: five products per section, each through a coefficient read,
// a multiply and an accumulate stage, then round and history write per
// section and a result store per channel. At the publish step the pair
// goes to the response register and the block returns to idle.
// The response sits in its own register: a stalled receiver holds the next
// pair at its publish step; until that pair arrives there, requests are
// still taken in idle while the response is pending.
// Reset sets every b0 to 1.0 and all other coefficients and all history
// to zero; the block then passes samples through unchanged.
module stereo_biquad_cascade_eq import sbqeq_pkg::*; #(
  parameter int NUM_SECTIONS = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

  cmd_t             cmd;
  logic [SEC_W-1:0] sec;
  logic [CH_W-1:0]  ch;

  sbqeq_ctrl #(
    .NUM_SECTIONS(NUM_SECTIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .func      (req.func),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sec       (sec),
    .ch        (ch)
  );

  sbqeq_dp #(
    .NUM_SECTIONS(NUM_SECTIONS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sec (sec),
    .ch  (ch),
    .rsp (rsp)
  );

`ifndef SYNTHESIS
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!rsp_valid || rsp_ready))
    else $error("response overwritten while still pending");

  a_rsp_from_publish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.publish))
    else $error("response valid without publish");

  a_fin_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> $past(cmd.sec_done))
    else $error("channel finish without last section done");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sbqeq_pkg::*;

  localparam int NSEC = 5;
  localparam int NCOEF = NSEC * TAPS;
  localparam logic [FUNC_BITS-1:0] FUNC_UNDEF = 2'd3;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  coef_t coef_bank [NCOEF];
  // index 0: raw input history, index s+1: output history of section s
  sample_t hist [NUM_CHANNELS][NSEC+1][2];
  rsp_t expected_pairs [$];
  rsp_t want;
  int errors;
  bit sender_idle;
  bit receiver_idle;
  bit hold_request;
  bit offering;

  stereo_biquad_cascade_eq #(
    .NUM_SECTIONS(NSEC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  initial begin
    #6ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, longint want_v, longint got_v);
    $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    errors++;
  endtask

  function automatic sample_t round_to_sample(longint acc);
    longint v;
    v = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return sample_t'(v);
  endfunction

  function automatic sample_t channel_filter(int ch, sample_t x_in);
    longint acc;
    sample_t x;
    sample_t y;
    int base;
    x = x_in;
    for (int s = 0; s < NSEC; s++) begin
      base = s * TAPS;
      acc = longint'(coef_bank[base + int'(TAP_B0)]) * longint'(x)
          + longint'(coef_bank[base + int'(TAP_B1)]) * longint'(hist[ch][s][0])
          + longint'(coef_bank[base + int'(TAP_B2)]) * longint'(hist[ch][s][1])
          - longint'(coef_bank[base + int'(TAP_A1)]) * longint'(hist[ch][s+1][0])
          - longint'(coef_bank[base + int'(TAP_A2)]) * longint'(hist[ch][s+1][1]);
      y = round_to_sample(acc);
      hist[ch][s][1] = hist[ch][s][0];
      hist[ch][s][0] = x;
      x = y;
    end
    hist[ch][NSEC][1] = hist[ch][NSEC][0];
    hist[ch][NSEC][0] = x;
    return x;
  endfunction

  function automatic void apply_request(req_t r);
    rsp_t e;
    case (r.func)
      FUNC_PROC: begin
        e.left_out = channel_filter(0, r.left_in);
        e.right_out = channel_filter(1, r.right_in);
        expected_pairs.push_back(e);
      end
      FUNC_COEF_WR: begin
        if (r.coef_index < NCOEF) coef_bank[r.coef_index] = r.coef_value;
      end
      FUNC_HIST_CLR: begin
        foreach (hist[c, s, k]) hist[c][s][k] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic req_t make_req(logic [FUNC_BITS-1:0] f, sample_t l, sample_t r,
                                    logic [CIDX_BITS-1:0] idx, coef_t val);
    req_t q;
    q.func = f;
    q.left_in = l;
    q.right_in = r;
    q.coef_index = idx;
    q.coef_value = val;
    return q;
  endfunction

  function automatic sample_t rand_sample();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return SAMPLE_MAX;
    if (mode == 1) return SAMPLE_MIN;
    if (mode < 5) return sample_t'($urandom()) >>> 8;
    return sample_t'($urandom());
  endfunction

  task automatic send_request(input req_t r);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      if (offering) req_valid <= 1'b0;
      offering = 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    offering = 1;
    do @(posedge clk); while (req_ready !== 1'b1);
    apply_request(r);
  endtask

  task automatic send_pair(sample_t l, sample_t r);
    send_request(make_req(FUNC_PROC, l, r, '0, '0));
  endtask

  task automatic send_coef(int idx, coef_t val);
    send_request(make_req(FUNC_COEF_WR, '0, '0, CIDX_BITS'(idx), val));
  endtask

  task automatic wait_drained;
    if (offering) req_valid <= 1'b0;
    offering = 0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected response, left_out", 0, rsp.left_out);
      end else begin
        want = expected_pairs.pop_front();
        if (rsp.left_out !== want.left_out)
          report_mismatch("left_out", want.left_out, rsp.left_out);
        if (rsp.right_out !== want.right_out)
          report_mismatch("right_out", want.right_out, rsp.right_out);
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ready <= 1'b1;
      end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic test_passthrough;
    send_pair('0, '0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(-24'sd1, 24'sd1);
    send_pair(sample_t'($urandom()), sample_t'($urandom()));
  endtask

  task automatic test_coef_extremes;
    send_coef(int'(TAP_B0), 32'sh7FFF_FFFF);
    send_coef(int'(TAP_A1), 32'sh8000_0000);
    send_coef(NCOEF, '0);
    send_coef(31, '0);
    send_request(make_req(FUNC_UNDEF, '0, '0, CIDX_BITS'(int'(TAP_B0)), '0));
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(24'sd1, -24'sd1);
    send_pair('0, '0);
    send_request(make_req(FUNC_HIST_CLR, '0, '0, '0, '0));
    send_pair(24'sh001000, -24'sh001000);
    send_coef(int'(TAP_B0), COEF_ONE);
    send_coef(int'(TAP_A1), '0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
  endtask

  task automatic test_stable_sets;
    longint a1;
    longint a2;
    longint lim;
    int base;
    for (int set = 0; set < 6; set++) begin
      for (int s = 0; s < NSEC; s++) begin
        base = s * TAPS;
        // keep poles inside the unit circle: |a2| < 1, |a1| < 1 + a2
        a2 = longint'($urandom_range(0, 120795955)) - 60397977;
        lim = ((longint'(1) << COEF_FRAC_BITS) + a2) * 15 / 16;
        a1 = longint'($urandom_range(0, 2 * lim)) - lim;
        send_coef(base + int'(TAP_B0), coef_t'(longint'($urandom_range(0, 1 << 27)) - (1 << 26)));
        send_coef(base + int'(TAP_B1), coef_t'(longint'($urandom_range(0, 1 << 27)) - (1 << 26)));
        send_coef(base + int'(TAP_B2), coef_t'(longint'($urandom_range(0, 1 << 27)) - (1 << 26)));
        send_coef(base + int'(TAP_A1), coef_t'(a1));
        send_coef(base + int'(TAP_A2), coef_t'(a2));
      end
      send_request(make_req(FUNC_HIST_CLR, rand_sample(), rand_sample(), '0, '0));
      repeat (60) send_pair(rand_sample(), rand_sample());
    end
  endtask

  task automatic test_random_mix(int count);
    int pick;
    coef_t val;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_request(make_req(FUNC_PROC, rand_sample(), rand_sample(),
                              CIDX_BITS'($urandom()), coef_t'($urandom())));
      end else if (pick < 88) begin
        val = $urandom_range(0, 1) ? coef_t'($urandom()) : coef_t'($urandom()) >>> 6;
        send_request(make_req(FUNC_COEF_WR, rand_sample(), rand_sample(),
                              CIDX_BITS'($urandom()), val));
      end else if (pick < 94) begin
        send_request(make_req(FUNC_HIST_CLR, rand_sample(), rand_sample(),
                              CIDX_BITS'($urandom()), coef_t'($urandom())));
      end else begin
        send_request(make_req(FUNC_UNDEF, rand_sample(), rand_sample(),
                              CIDX_BITS'($urandom()), coef_t'($urandom())));
      end
    end
  endtask

  task automatic test_receiver_holdoff;
    sender_idle = 0;
    hold_request = 1;
    repeat (16) send_pair(rand_sample(), rand_sample());
    wait_drained;
    sender_idle = 1;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    errors = 0;
    sender_idle = 1;
    receiver_idle = 1;
    hold_request = 0;
    offering = 0;
    foreach (coef_bank[i]) coef_bank[i] = '0;
    for (int s = 0; s < NSEC; s++) coef_bank[s * TAPS + int'(TAP_B0)] = COEF_ONE;
    foreach (hist[c, s, k]) hist[c][s][k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_passthrough;
    test_coef_extremes;
    test_stable_sets;
    test_random_mix(540);
    test_receiver_holdoff;
    sender_idle = 0;
    receiver_idle = 0;
    test_random_mix(250);

    wait_drained;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sbqeq_pkg.sv
sv/sbqeq_dp.sv
sv/sbqeq_ctrl.sv
sv/stereo_biquad_cascade_eq.sv
sim/tb_top.sv
